// ----- sv/line_substring_filter_macros.svh -----
// ----------------------------------------------------------------------------
// line_substring_filter_macros.svh
// Assertion macros for the line substring filter (clocked on clk_i, reset rst_ni).
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_FILTER_MACROS_SVH
`define LINE_SUBSTRING_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define LSF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LSF_ASSERT_NOW(name, ante, cons, msg)
`define LSF_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- sv/lsf_pkg.sv -----
// ----------------------------------------------------------------------------
// lsf_pkg
// Types and constants for the line substring filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 64;
  localparam int unsigned PLEN_W          = 7;
  localparam int unsigned COUNT_W         = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [7:0]         NEWLINE   = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // action codes
  localparam logic [1:0] ACT_PATTERN = 2'd0;
  localparam logic [1:0] ACT_TEXT    = 2'd1;
  localparam logic [1:0] ACT_END     = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SELECT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT    = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    logic [5:0] pattern_index;
  } in_item_t;

  typedef struct packed {
    logic               line_selected;
    logic               line_ended;
    logic [COUNT_W-1:0] selected_total;
    logic               limit_hit;
    logic               input_done;
  } out_item_t;

endpackage

// ----- sv/line_substring_filter.sv -----
// ----------------------------------------------------------------------------
// line_substring_filter
// Fixed-string line filter: selects text lines that hold a loaded pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry an action: write a pattern byte at pattern_index, feed
//   one text byte (newline 10 closes a line), or mark end of input. Newlines
//   and end of input each give one result word; other words give none.
//   Config registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while
//   no word is in flight.
// Timing:
//   One input word per cycle while no result is stalled. A word waits in the
//   input register; the compare against a 64-byte sliding window (one barrel
//   shift plus parallel byte compares) and the line bookkeeping run
//   combinationally from it, and the result word is registered at the output.
// Stall:
//   A stalled result holds in the output register. A word that produces a
//   result then waits in the input register, and in_stall_o rises; words that
//   produce no result do not wait on the output.
// Reset:
//   Clears the config, counters, line state and window. Pattern bytes are
//   undefined until written.
// ----------------------------------------------------------------------------
module line_substring_filter
  import lsf_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "line_substring_filter_macros.svh"

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CmpW = (LenW > PLEN_W) ? LenW : PLEN_W;
  localparam int unsigned WinW = 8 * PATTERN_MAX;

  // config
  logic [PLEN_W-1:0]  pattern_length_q;
  logic               invert_select_q;
  logic               limit_enable_q;
  logic [COUNT_W-1:0] match_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= '0;
      invert_select_q  <= 1'b0;
      limit_enable_q   <= 1'b0;
      match_limit_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[PLEN_W-1:0];
        CFG_INVERT_SELECT:  invert_select_q  <= cfg_data_i[0];
        CFG_LIMIT_ENABLE:   limit_enable_q   <= cfg_data_i[0];
        CFG_MATCH_LIMIT:    match_limit_q    <= cfg_data_i[COUNT_W-1:0];
      endcase
    end
  end

  // input register
  logic     in_vld_q;
  in_item_t in_q;
  logic     accept_in;
  logic     proc;

  logic is_text, is_nl, is_end, is_pat, gives_result, out_free;
  logic out_vld_q;

  assign is_text      = (in_q.action == ACT_TEXT);
  assign is_nl        = is_text && (in_q.byte_value == NEWLINE);
  assign is_end       = (in_q.action == ACT_END);
  assign is_pat       = (in_q.action == ACT_PATTERN);
  assign gives_result = is_nl || is_end;
  assign out_free     = !out_vld_q || !out_stall_i;

  // Words with no result never wait on the output side.
  assign proc       = in_vld_q && (!gives_result || out_free);
  assign in_stall_o = in_vld_q && !proc;
  assign accept_in  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept_in) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_q <= in_item_i;
    end
  end

  // pattern store: one register per byte, no reset
  logic [PATTERN_MAX-1:0][7:0] pat_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (proc && is_pat && (32'(in_q.pattern_index) == j)) begin
        pat_q[j] <= in_q.byte_value;
      end
    end
  end

  // line state
  logic [PATTERN_MAX-1:0][7:0] recent_q, recent_d;   // newest byte at 0
  logic [CmpW-1:0]             bytes_in_line_q, bytes_in_line_d;
  logic                        line_has_match_q, line_has_match_d;
  logic                        line_open_q, line_open_d;
  logic [COUNT_W-1:0]          selected_count_q, selected_count_d;
  logic                        stopped_q, stopped_d;

  // effective pattern length, saturated to the store depth
  logic [CmpW-1:0] plen_ext, eff_len;
  assign plen_ext = CmpW'(pattern_length_q);
  assign eff_len  = (plen_ext > CmpW'(PATTERN_MAX)) ? CmpW'(PATTERN_MAX) : plen_ext;

  // window including the incoming byte
  logic [PATTERN_MAX-1:0][7:0] win_d;
  logic [WinW-1:0]             rev_w, aligned_w;
  logic [CmpW-1:0]             sh_bytes;
  logic [CmpW+2:0]             sh_bits;
  logic                        all_eq;
  logic [CmpW-1:0]             bil_inc;
  logic                        hit;

  always_comb begin
    win_d[0] = in_q.byte_value;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_d[k] = recent_q[k-1];
    end
  end

  // Reverse the window, then shift so that aligned byte j lines up with
  // pattern byte j: aligned[j] = window[eff_len-1-j].
  always_comb begin
    for (int m = 0; m < PATTERN_MAX; m++) begin
      rev_w[8*m +: 8] = win_d[PATTERN_MAX-1-m];
    end
  end

  assign sh_bytes  = CmpW'(PATTERN_MAX) - eff_len;
  assign sh_bits   = {sh_bytes, 3'b000};
  assign aligned_w = rev_w >> sh_bits;

  always_comb begin
    all_eq = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if ((CmpW'(j) < eff_len) && (aligned_w[8*j +: 8] != pat_q[j])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign bil_inc = (bytes_in_line_q < CmpW'(PATTERN_MAX)) ? bytes_in_line_q + CmpW'(1)
                                                          : bytes_in_line_q;
  assign hit     = (eff_len != '0) && (bil_inc >= eff_len) && all_eq;

  // line end decision
  logic               want, stop_pre, sel, stop_post;
  logic [COUNT_W-1:0] count_post;

  always_comb begin
    want       = (line_has_match_q || (eff_len == '0)) != invert_select_q;
    stop_pre   = stopped_q || (limit_enable_q && (selected_count_q >= match_limit_q));
    sel        = want && !stop_pre;
    count_post = (sel && (selected_count_q != COUNT_MAX)) ? selected_count_q + COUNT_W'(1)
                                                          : selected_count_q;
    stop_post  = stop_pre || (limit_enable_q && (count_post >= match_limit_q));
  end

  always_comb begin
    recent_d         = recent_q;
    bytes_in_line_d  = bytes_in_line_q;
    line_has_match_d = line_has_match_q;
    line_open_d      = line_open_q;
    selected_count_d = selected_count_q;
    stopped_d        = stopped_q;
    if (proc) begin
      unique case (in_q.action)
        ACT_PATTERN: begin
        end
        ACT_TEXT: begin
          if (!is_nl) begin
            recent_d         = win_d;
            bytes_in_line_d  = bil_inc;
            line_open_d      = 1'b1;
            line_has_match_d = line_has_match_q || hit;
          end else begin
            selected_count_d = count_post;
            stopped_d        = stop_post;
            recent_d         = '0;
            bytes_in_line_d  = '0;
            line_has_match_d = 1'b0;
            line_open_d      = 1'b0;
          end
        end
        ACT_END: begin
          // per-input state cleared after the final report
          selected_count_d = '0;
          stopped_d        = 1'b0;
          recent_d         = '0;
          bytes_in_line_d  = '0;
          line_has_match_d = 1'b0;
          line_open_d      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q         <= '0;
      bytes_in_line_q  <= '0;
      line_has_match_q <= 1'b0;
      line_open_q      <= 1'b0;
      selected_count_q <= '0;
      stopped_q        <= 1'b0;
    end else begin
      recent_q         <= recent_d;
      bytes_in_line_q  <= bytes_in_line_d;
      line_has_match_q <= line_has_match_d;
      line_open_q      <= line_open_d;
      selected_count_q <= selected_count_d;
      stopped_q        <= stopped_d;
    end
  end

  // result register
  out_item_t out_d, out_q;
  logic      ended;
  logic      load_out;

  assign ended    = is_nl || (is_end && line_open_q);
  assign load_out = proc && gives_result;

  always_comb begin
    out_d.line_selected  = ended && sel;
    out_d.line_ended     = ended;
    out_d.selected_total = ended ? count_post : selected_count_q;
    out_d.limit_hit      = ended ? stop_post : stopped_q;
    out_d.input_done     = is_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // checks
  `LSF_ASSERT_NEXT(a_end_clears, proc && is_end, (selected_count_q == '0) && !stopped_q && !line_open_q, "end of input left per-input state")
  `LSF_ASSERT_NOW(a_open_tracks_len, 1'b1, line_open_q == (bytes_in_line_q != '0), "line open flag and byte count disagree")
  `LSF_ASSERT_NOW(a_sel_needs_end, out_vld_q && out_q.line_selected, out_q.line_ended, "selected result without a line end")

endmodule
